// File: rtl/tolc_pkg.sv
// Shared types and constants for the terminal output line cleaner.
// No dependencies; used by tolc_ctrl, tolc_datapath and the top level.
package tolc_pkg;

   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_H      = 8'h68;
   localparam logic [7:0] CH_L      = 8'h6C;
   localparam logic [7:0] CH_M      = 8'h6D;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ESC,
      PH_BRACKET,
      PH_PARAMS
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLAY,
      ST_PLAIN,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_STEP,
      OP_LATCH,
      OP_REPLAY,
      OP_PLAIN,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic need_release;
      logic emits;
      logic replay_last;
      logic latched_emits;
      logic emit_last;
   } status_type;

endpackage

// File: rtl/terminal_output_line_cleaner.sv
// Terminal output line cleaner: strips colour and private-mode escapes, edits lines.
// A plain byte or a kept or dropped escape byte is handled at once; a rejected escape
// sequence's held bytes are replayed (one store write per held byte), then the new item.
// A newline or flush then emits max(1, line length) transfers at one per cycle
// whenever rsp_tready is high, paced by the line store's single registered read port.
// Synchronous reset clears cursor, mark, escape state and overflow; stores are kept.
module terminal_output_line_cleaner #(
   parameter int LINE_MAX = 64,
   parameter int HOLD_MAX = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic       req_tuser,  // [0] mode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] line_byte
   output logic       rsp_tlast,
   output logic [2:0] rsp_tuser   // [0] line_empty, [1] line_ended, [2] line_truncated
);

   tolc_pkg::op_type     op;
   tolc_pkg::status_type status;
   logic                 empty, ended, truncated;

   tolc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .op         (op)
   );

   tolc_datapath #(
      .LINE_MAX (LINE_MAX),
      .HOLD_MAX (HOLD_MAX)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .req_mode      (req_tuser),
      .req_byte      (req_tdata),
      .status        (status),
      .rsp_byte      (rsp_tdata),
      .rsp_last      (rsp_tlast),
      .rsp_empty     (empty),
      .rsp_ended     (ended),
      .rsp_truncated (truncated)
   );

   assign rsp_tuser = {truncated, ended, empty};

endmodule

// File: rtl/tolc_ctrl.sv
// Sequencer for the line cleaner: accepts items, runs escape replay and line emission.
// Depends on tolc_pkg; drives tolc_datapath through an op code and reads its status.
module tolc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  tolc_pkg::status_type status,
   output tolc_pkg::op_type     op
);

   tolc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tolc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = tolc_pkg::OP_NONE;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         tolc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (status.need_release) begin
                  op       = tolc_pkg::OP_LATCH;
                  state_in = tolc_pkg::ST_REPLAY;
               end else begin
                  op = tolc_pkg::OP_STEP;
                  if (status.emits) begin
                     state_in = tolc_pkg::ST_EMIT;
                  end
               end
            end
         end
         tolc_pkg::ST_REPLAY: begin
            op = tolc_pkg::OP_REPLAY;
            if (status.replay_last) begin
               state_in = tolc_pkg::ST_PLAIN;
            end
         end
         tolc_pkg::ST_PLAIN: begin
            op = tolc_pkg::OP_PLAIN;
            state_in = status.latched_emits ? tolc_pkg::ST_EMIT : tolc_pkg::ST_IDLE;
         end
         tolc_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               op = tolc_pkg::OP_EMIT;
               if (status.emit_last) begin
                  state_in = tolc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = tolc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/tolc_datapath.sv
// Datapath of the line cleaner: line store, held escape bytes, cursor and escape decode.
// Depends on tolc_pkg; sequenced by tolc_ctrl.
module tolc_datapath #(
   parameter int LINE_MAX = 64,
   parameter int HOLD_MAX = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tolc_pkg::op_type     op,
   input  logic                 req_mode,
   input  logic [7:0]           req_byte,
   output tolc_pkg::status_type status,
   output logic [7:0]           rsp_byte,
   output logic                 rsp_last,
   output logic                 rsp_empty,
   output logic                 rsp_ended,
   output logic                 rsp_truncated
);

   localparam int IW  = $clog2(LINE_MAX);
   localparam int CW  = $clog2(LINE_MAX + 1);
   localparam int HIW = $clog2(HOLD_MAX);
   localparam int HCW = $clog2(HOLD_MAX + 1);

   logic [7:0] line_mem [LINE_MAX];
   logic [7:0] hold_mem [HOLD_MAX];

   logic [CW-1:0]       cursor_ff, cursor_in, mark_ff, mark_in;
   tolc_pkg::phase_type phase_ff, phase_in;
   logic                priv_ff, priv_in, ovf_ff, ovf_in;
   logic [HCW-1:0]      hc_ff, hc_in;
   logic [HIW-1:0]      rp_ff, rp_in;
   logic [IW-1:0]       ptr_ff, ptr_in;
   logic [7:0]          byte_ff, byte_in;
   logic                mode_ff, mode_in, ended_ff, ended_in;
   logic [7:0]          rd_ff, hold_rd_ff;

   logic          lwe, hwe, lit_en, do_plain;
   logic [IW-1:0] lwa;
   logic [HIW-1:0] hwa;
   logic [7:0]    hwd, lit_byte, pb;
   logic [CW-1:0] len, cur_back;
   logic          is_digit, is_letter, room, in_seq, absorb, drop, last_rep;

   assign len       = (cursor_ff > mark_ff) ? cursor_ff : mark_ff;
   assign is_digit  = ((req_byte >= tolc_pkg::CH_ZERO) && (req_byte <= tolc_pkg::CH_NINE))
                      || (req_byte == tolc_pkg::CH_SEMI);
   assign is_letter = ((req_byte >= tolc_pkg::CH_UPPER_A) && (req_byte <= tolc_pkg::CH_UPPER_Z))
                      || ((req_byte >= tolc_pkg::CH_LOWER_A) && (req_byte <= tolc_pkg::CH_LOWER_Z));
   assign room      = hc_ff < HCW'(HOLD_MAX);
   assign in_seq    = (phase_ff == tolc_pkg::PH_BRACKET) || (phase_ff == tolc_pkg::PH_PARAMS);

   always_comb begin
      absorb = 1'b0;
      case (phase_ff)
         tolc_pkg::PH_ESC:     absorb = room && (req_byte == tolc_pkg::CH_LBRACK);
         tolc_pkg::PH_BRACKET: absorb = room && ((req_byte == tolc_pkg::CH_QMARK) || is_digit);
         tolc_pkg::PH_PARAMS:  absorb = room && is_digit;
         default:              absorb = 1'b0;
      endcase
   end

   assign drop = in_seq && is_letter && !absorb &&
                 (priv_ff ? ((req_byte == tolc_pkg::CH_H) || (req_byte == tolc_pkg::CH_L))
                          : (req_byte == tolc_pkg::CH_M));

   assign last_rep = (HCW'(rp_ff) + HCW'(1)) == hc_ff;

   assign status.need_release  = (phase_ff != tolc_pkg::PH_IDLE) &&
                                 (req_mode || (!absorb && !drop));
   assign status.emits         = (phase_ff == tolc_pkg::PH_IDLE) &&
                                 (req_mode || (req_byte == tolc_pkg::CH_LF));
   assign status.replay_last   = last_rep;
   assign status.latched_emits = mode_ff || (byte_ff == tolc_pkg::CH_LF);
   assign status.emit_last     = (len == '0) || ((CW'(ptr_ff) + CW'(1)) == len);

   assign rsp_empty     = (len == '0);
   assign rsp_byte      = rsp_empty ? 8'h00 : rd_ff;
   assign rsp_last      = status.emit_last;
   assign rsp_ended     = ended_ff;
   assign rsp_truncated = ovf_ff;

   assign cur_back = (cursor_ff != '0) ? (cursor_ff - CW'(1)) : '0;
   assign do_plain = ((op == tolc_pkg::OP_STEP) && (phase_ff == tolc_pkg::PH_IDLE) && !req_mode)
                     || ((op == tolc_pkg::OP_PLAIN) && !mode_ff);
   assign pb       = (op == tolc_pkg::OP_PLAIN) ? byte_ff : req_byte;

   always_comb begin
      cursor_in = cursor_ff;
      mark_in   = mark_ff;
      phase_in  = phase_ff;
      priv_in   = priv_ff;
      hc_in     = hc_ff;
      ovf_in    = ovf_ff;
      rp_in     = rp_ff;
      ptr_in    = ptr_ff;
      byte_in   = byte_ff;
      mode_in   = mode_ff;
      ended_in  = ended_ff;
      lit_en    = 1'b0;
      lit_byte  = pb;
      hwe       = 1'b0;
      hwa       = hc_ff[HIW-1:0];
      hwd       = req_byte;
      lwe       = 1'b0;
      lwa       = cursor_ff[IW-1:0];

      if (op == tolc_pkg::OP_STEP || op == tolc_pkg::OP_LATCH) begin
         ended_in = !req_mode;
      end
      if (op == tolc_pkg::OP_LATCH) begin
         byte_in = req_byte;
         mode_in = req_mode;
      end

      if (op == tolc_pkg::OP_STEP && phase_ff != tolc_pkg::PH_IDLE && !req_mode) begin
         if (absorb) begin
            hwe   = 1'b1;
            hc_in = hc_ff + HCW'(1);
            if (phase_ff == tolc_pkg::PH_ESC) begin
               phase_in = tolc_pkg::PH_BRACKET;
            end else begin
               phase_in = tolc_pkg::PH_PARAMS;
               if (phase_ff == tolc_pkg::PH_BRACKET && req_byte == tolc_pkg::CH_QMARK) begin
                  priv_in = 1'b1;
               end
            end
         end else if (drop) begin
            hc_in    = '0;
            phase_in = tolc_pkg::PH_IDLE;
            priv_in  = 1'b0;
         end
      end

      if (do_plain) begin
         case (pb)
            tolc_pkg::CH_BS: begin
               cursor_in = cur_back;
               if (mark_ff == (cur_back + CW'(1))) begin
                  mark_in = mark_ff - CW'(1);
               end
            end
            tolc_pkg::CH_CR: begin
               mark_in   = len;
               cursor_in = '0;
            end
            tolc_pkg::CH_LF: begin
            end
            tolc_pkg::CH_ESC: begin
               hwe      = 1'b1;
               hwa      = '0;
               hwd      = pb;
               hc_in    = HCW'(1);
               phase_in = tolc_pkg::PH_ESC;
               priv_in  = 1'b0;
            end
            default: begin
               lit_en = 1'b1;
            end
         endcase
      end

      if (op == tolc_pkg::OP_REPLAY) begin
         lit_en   = 1'b1;
         lit_byte = hold_rd_ff;
         if (last_rep) begin
            rp_in    = '0;
            hc_in    = '0;
            phase_in = tolc_pkg::PH_IDLE;
            priv_in  = 1'b0;
         end else begin
            rp_in = rp_ff + HIW'(1);
         end
      end

      if (lit_en) begin
         if (cursor_ff < CW'(LINE_MAX)) begin
            lwe       = 1'b1;
            cursor_in = cursor_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (op == tolc_pkg::OP_EMIT) begin
         if (status.emit_last) begin
            ptr_in = '0;
            if (ended_ff) begin
               cursor_in = '0;
               mark_in   = '0;
               ovf_in    = 1'b0;
            end
         end else begin
            ptr_in = ptr_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         mark_ff   <= '0;
         phase_ff  <= tolc_pkg::PH_IDLE;
         priv_ff   <= 1'b0;
         hc_ff     <= '0;
         ovf_ff    <= 1'b0;
         rp_ff     <= '0;
         ptr_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         mark_ff   <= mark_in;
         phase_ff  <= phase_in;
         priv_ff   <= priv_in;
         hc_ff     <= hc_in;
         ovf_ff    <= ovf_in;
         rp_ff     <= rp_in;
         ptr_ff    <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      mode_ff  <= mode_in;
      ended_ff <= ended_in;
   end

   // line store: one write port, registered read of the next column
   always_ff @(posedge clock) begin
      if (lwe) begin
         line_mem[lwa] <= lit_byte;
      end
      rd_ff <= line_mem[ptr_in];
   end

   // held escape bytes, read ahead for replay
   always_ff @(posedge clock) begin
      if (hwe) begin
         hold_mem[hwa] <= hwd;
      end
      hold_rd_ff <= hold_mem[rp_in];
   end

endmodule

// File: tb/terminal_output_line_cleaner_tb.sv
// Self-checking testbench for terminal_output_line_cleaner: streams terminal bytes and
// flushes, predicts every line transfer with an in-bench line editor and checks them.
// Depends on tolc_pkg and the terminal_output_line_cleaner RTL.
module terminal_output_line_cleaner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_MAX = 64;
   localparam int HOLD_MAX = 16;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       empty;
      logic       ended;
      logic       trunc;
   } line_beat_type;

   typedef struct packed {
      logic       flush;
      logic [7:0] ch;
      logic       settle;
   } term_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;  // [7:0] data_byte
   logic       req_tuser = 1'b0;   // [0] mode
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] line_byte
   logic       rsp_tlast;
   logic [2:0] rsp_tuser;          // [0] line_empty, [1] line_ended, [2] line_truncated

   terminal_output_line_cleaner #(
      .LINE_MAX(LINE_MAX),
      .HOLD_MAX(HOLD_MAX)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // line editor state
   logic [7:0]          line_buf [LINE_MAX];
   logic [6:0]          col;
   logic [6:0]          mark;
   tolc_pkg::phase_type esc_phase;
   logic                esc_private;
   logic [7:0]          esc_held [HOLD_MAX];
   logic [4:0]          esc_count;
   logic                line_dropped;

   line_beat_type line_expect [$];
   term_item_type term_stream [$];
   term_item_type term_head;
   logic       settle_next = 1'b0;
   int         stim_count = 0;
   int         fail_count = 0;
   int         send_burst = 0;
   int         send_gap = 0;
   logic [9:0] stall_cycle = '0;

   task automatic put_char(input logic [7:0] b);
      if (col < LINE_MAX) begin
         line_buf[col[5:0]] = b;
         col++;
      end else begin
         line_dropped = 1'b1;
      end
   endtask

   task automatic spill_escape();
      for (int j = 0; j < esc_count; j++) put_char(esc_held[4'(j)]);
      esc_count = '0;
      esc_phase = tolc_pkg::PH_IDLE;
      esc_private = 1'b0;
   endtask

   function automatic bit stash_escape(input logic [7:0] b);
      if (esc_count >= HOLD_MAX) return 1'b0;
      esc_held[esc_count[3:0]] = b;
      esc_count++;
      return 1'b1;
   endfunction

   task automatic emit_line(input logic ended);
      logic [6:0] len;
      len = (col > mark) ? col : mark;
      if (len == 0) begin
         line_expect.push_back('{8'h00, 1'b1, 1'b1, ended, line_dropped});
      end else begin
         for (int j = 0; j < len; j++)
            line_expect.push_back('{line_buf[6'(j)], j + 1 == len, 1'b0, ended,
                                    line_dropped});
      end
   endtask

   task automatic plain_char(input logic [7:0] b);
      if (b == tolc_pkg::CH_BS) begin
         if (col > 0) col--;
         if (mark == col + 7'd1) mark--;
      end else if (b == tolc_pkg::CH_CR) begin
         if (col > mark) mark = col;
         col = '0;
      end else if (b == tolc_pkg::CH_LF) begin
         emit_line(1'b1);
         col = '0;
         mark = '0;
         line_dropped = 1'b0;
      end else if (b == tolc_pkg::CH_ESC) begin
         esc_held[0] = b;
         esc_count = 5'd1;
         esc_phase = tolc_pkg::PH_ESC;
         esc_private = 1'b0;
      end else begin
         put_char(b);
      end
   endtask

   task automatic edit_line_item(input logic flush, input logic [7:0] b);
      logic digit;
      logic letter;
      logic taken;
      digit = (b >= tolc_pkg::CH_ZERO && b <= tolc_pkg::CH_NINE) || b == tolc_pkg::CH_SEMI;
      letter = (b >= tolc_pkg::CH_UPPER_A && b <= tolc_pkg::CH_UPPER_Z) ||
               (b >= tolc_pkg::CH_LOWER_A && b <= tolc_pkg::CH_LOWER_Z);
      taken = 1'b0;
      if (flush) begin
         if (esc_phase != tolc_pkg::PH_IDLE) spill_escape();
         emit_line(1'b0);
      end else if (esc_phase == tolc_pkg::PH_IDLE) begin
         plain_char(b);
      end else begin
         case (esc_phase)
            tolc_pkg::PH_ESC: begin
               if (b == tolc_pkg::CH_LBRACK) begin
                  if (stash_escape(b)) begin
                     esc_phase = tolc_pkg::PH_BRACKET;
                     taken = 1'b1;
                  end
               end
            end
            tolc_pkg::PH_BRACKET: begin
               if (b == tolc_pkg::CH_QMARK) begin
                  if (stash_escape(b)) begin
                     esc_private = 1'b1;
                     esc_phase = tolc_pkg::PH_PARAMS;
                     taken = 1'b1;
                  end
               end else if (digit) begin
                  if (stash_escape(b)) begin
                     esc_phase = tolc_pkg::PH_PARAMS;
                     taken = 1'b1;
                  end
               end
            end
            default: begin
               if (digit) begin
                  if (stash_escape(b)) begin
                     esc_phase = tolc_pkg::PH_PARAMS;
                     taken = 1'b1;
                  end
               end
            end
         endcase
         if (!taken) begin
            if ((esc_phase == tolc_pkg::PH_BRACKET || esc_phase == tolc_pkg::PH_PARAMS) &&
                letter &&
                (esc_private ? (b == tolc_pkg::CH_H || b == tolc_pkg::CH_L)
                             : (b == tolc_pkg::CH_M))) begin
               esc_count = '0;
               esc_phase = tolc_pkg::PH_IDLE;
               esc_private = 1'b0;
            end else begin
               spill_escape();
               plain_char(b);
            end
         end
      end
   endtask

   // stimulus helpers
   task automatic push_item(input logic flush, input logic [7:0] b);
      term_stream.push_back('{flush, b, settle_next});
      settle_next = 1'b0;
      stim_count++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_item(1'b0, b);
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_params(input int n);
      for (int i = 0; i < n; i++)
         push_byte(($urandom_range(0, 4) == 0) ? tolc_pkg::CH_SEMI
                                               : 8'(tolc_pkg::CH_ZERO + $urandom_range(0, 9)));
   endtask

   function automatic logic [7:0] rand_letter();
      return $urandom_range(0, 1) ? 8'(tolc_pkg::CH_UPPER_A + $urandom_range(0, 25))
                                  : 8'(tolc_pkg::CH_LOWER_A + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_text();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   task automatic random_run(input int n);
      int stop;
      int kind;
      stop = stim_count + n;
      while (stim_count < stop) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               repeat ($urandom_range(1, 8)) push_byte(rand_text());
            end
            3: begin
               push_byte(tolc_pkg::CH_ESC);
               push_byte(tolc_pkg::CH_LBRACK);
               push_params($urandom_range(0, 4));
               push_byte(tolc_pkg::CH_M);
            end
            4: begin
               push_byte(tolc_pkg::CH_ESC);
               push_byte(tolc_pkg::CH_LBRACK);
               push_byte(tolc_pkg::CH_QMARK);
               push_params($urandom_range(0, 4));
               push_byte($urandom_range(0, 3) == 0 ? rand_letter() :
                         ($urandom_range(0, 1) ? tolc_pkg::CH_H : tolc_pkg::CH_L));
            end
            5: begin
               push_byte(tolc_pkg::CH_ESC);
               push_byte(tolc_pkg::CH_LBRACK);
               if ($urandom_range(0, 1)) push_byte(tolc_pkg::CH_QMARK);
               push_params($urandom_range(0, 3));
               push_byte(rand_letter());
            end
            6: begin
               push_byte(tolc_pkg::CH_ESC);
               if ($urandom_range(0, 3) != 0) begin
                  push_byte(tolc_pkg::CH_LBRACK);
                  if ($urandom_range(0, 2) == 0) push_byte(tolc_pkg::CH_QMARK);
                  push_params($urandom_range(0, 3));
               end
               case ($urandom_range(0, 3))
                  0: push_byte(tolc_pkg::CH_LF);
                  1: push_byte(tolc_pkg::CH_ESC);
                  2: push_byte(tolc_pkg::CH_BS);
                  default: push_byte(8'($urandom_range(0, 255)));
               endcase
            end
            7: begin
               if ($urandom_range(0, 1)) push_byte(tolc_pkg::CH_CR);
               else repeat ($urandom_range(1, 3)) push_byte(tolc_pkg::CH_BS);
            end
            8: begin
               settle_next = ($urandom_range(0, 5) == 0);
               push_byte(tolc_pkg::CH_LF);
            end
            default: begin
               settle_next = ($urandom_range(0, 5) == 0);
               push_item(1'b1, 8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   task automatic build_stimulus();
      push_item(1'b1, 8'hFF);
      push_byte(tolc_pkg::CH_LF);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_str("A");
      push_byte(tolc_pkg::CH_CR);
      push_byte(tolc_pkg::CH_BS);
      push_byte(tolc_pkg::CH_ESC);
      push_str("[3m");
      push_byte(tolc_pkg::CH_ESC);
      push_str("[?l");
      push_byte(tolc_pkg::CH_ESC);
      push_str("[J");
      push_byte(tolc_pkg::CH_ESC);
      push_str("x");
      push_byte(tolc_pkg::CH_ESC);
      push_byte(tolc_pkg::CH_ESC);
      push_byte(tolc_pkg::CH_LBRACK);
      push_item(1'b1, 8'h00);
      settle_next = 1'b1;
      push_byte(tolc_pkg::CH_LF);

      random_run(8);

      // over-long escapes, then a full line store
      push_byte(tolc_pkg::CH_ESC);
      push_byte(tolc_pkg::CH_LBRACK);
      push_params(15);
      push_byte(tolc_pkg::CH_M);
      push_byte(tolc_pkg::CH_ESC);
      push_str("[?");
      push_params(14);
      push_byte(tolc_pkg::CH_H);
      repeat (30) push_byte(8'($urandom_range(8'h20, 8'h7E)));
      push_byte(tolc_pkg::CH_ESC);
      push_str("[2J");
      push_item(1'b1, 8'h55);
      push_byte(tolc_pkg::CH_LF);

      random_run(8);
      push_byte(tolc_pkg::CH_LF);
   endtask

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         col = '0;
         mark = '0;
         esc_phase = tolc_pkg::PH_IDLE;
         esc_private = 1'b0;
         esc_count = '0;
         line_dropped = 1'b0;
         send_burst = $urandom_range(1, 24);
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) edit_line_item(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (term_stream.size() != 0 &&
                         (!term_stream[0].settle || line_expect.size() == 0)) begin
               term_head = term_stream.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= term_head.flush;
               req_tdata <= term_head.ch;
               send_burst--;
               if (send_burst <= 0) begin
                  send_burst = $urandom_range(1, 24);
                  send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern: free-flowing, light, heavy and periodic stretches
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 10'd1;
      case (stall_cycle[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_cycle[2:0] != 3'd0);
      endcase
   end

   // line transfer checker
   always @(posedge clock) begin
      line_beat_type want;
      line_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[1], rsp_tuser[2]};
         if (line_expect.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected line transfer: byte %02h last %b empty %b ended %b",
                     $time, got.ch, got.last, got.empty, got.ended);
            $display("%0t:    trunc %b", $time, got.trunc);
         end else begin
            want = line_expect.pop_front();
            if (want.empty) got.ch = want.ch;
            if (got !== want) begin
               fail_count++;
               $display("%0t: line transfer mismatch: expected byte %02h last %b empty %b",
                        $time, want.ch, want.last, want.empty);
               $display("%0t:    expected ended %b trunc %b", $time, want.ended, want.trunc);
               $display("%0t:    got byte %02h last %b empty %b ended %b trunc %b",
                        $time, rsp_tdata, got.last, got.empty, got.ended, got.trunc);
            end
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (term_stream.size() != 0 || req_tvalid);
      do @(posedge clock); while (line_expect.size() != 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && line_expect.size() == 0) begin
         $display("[terminal_output_line_cleaner] OK");
      end else begin
         $display("[terminal_output_line_cleaner] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[terminal_output_line_cleaner] ERROR");
      $finish;
   end

endmodule
